// ----- rtl/fri_pkg.sv -----
// ----------------------------------------------------------------------------
// fri_pkg
// Shared types and constants for the fuzzy rule inference block.
// ----------------------------------------------------------------------------
`default_nettype none

package fri_pkg;

    localparam int MAX_RULES_DEF = 64;
    localparam int DEG_W         = 16;
    localparam int DIV_Q_W       = 17;
    localparam int QDEPTH        = 2;
    localparam logic [DEG_W-1:0] PEAK_RESET = 16'hFFFF;

    typedef enum logic [1:0] {
        KIND_ZERO,
        KIND_FLAT,
        KIND_SLOPE
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [15:0]         num;
        logic [15:0]         den;
        logic [DEG_W-1:0]    height;
        logic signed [15:0]  rule_output;
        logic                last_term;
        logic                last_rule;
    } t_term;

    typedef struct packed {
        logic                done;
        logic                rem_nz;
        logic [DIV_Q_W-1:0]  quot;
    } t_div_res;

    typedef struct packed {
        logic signed [15:0]  crisp_output;
        logic                no_rule_fired;
        logic [6:0]          fired_rules;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/fri_front.sv -----
// ----------------------------------------------------------------------------
// fri_front
// Accepts antecedent terms and sorts each into zero, flat top or slope,
// with the slope numerator and denominator worked out for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module fri_front (
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    input  wire logic [127:0]  i_s_tdata,
    input  wire logic          i_s_tlast,
    input  wire logic          i_s_tuser,
    input  wire logic          i_full,
    output logic               o_push,
    output fri_pkg::t_term     o_term
);

    logic signed [15:0] w_xi;
    logic signed [15:0] w_ci;
    logic [15:0]        w_lb;
    logic [15:0]        w_lt;
    logic [15:0]        w_rb;
    logic [15:0]        w_rt;
    logic signed [17:0] w_x;
    logic signed [17:0] w_c;
    logic signed [17:0] w_lo;
    logic signed [17:0] w_hi;
    logic signed [17:0] w_lsh;
    logic signed [17:0] w_rsh;
    logic signed [17:0] w_lnum;
    logic signed [17:0] w_rnum;

    always_comb begin
        w_xi   = i_s_tdata[15:0];
        w_ci   = i_s_tdata[31:16];
        w_lb   = i_s_tdata[47:32];
        w_lt   = i_s_tdata[63:48];
        w_rb   = i_s_tdata[79:64];
        w_rt   = i_s_tdata[95:80];
        w_x    = {{2{w_xi[15]}}, w_xi};
        w_c    = {{2{w_ci[15]}}, w_ci};
        w_lo   = w_c - $signed({2'b00, w_lb});
        w_hi   = w_c + $signed({2'b00, w_rb});
        w_lsh  = w_c - $signed({2'b00, w_lt});
        w_rsh  = w_c + $signed({2'b00, w_rt});
        w_lnum = w_x - w_lo;
        w_rnum = w_hi - w_x;

        o_term.height      = i_s_tdata[111:96];
        o_term.rule_output = i_s_tdata[127:112];
        o_term.last_term   = i_s_tuser;
        o_term.last_rule   = i_s_tlast;
        o_term.kind        = fri_pkg::KIND_FLAT;
        o_term.num         = '0;
        o_term.den         = '0;

        if (w_x < w_lo || w_x > w_hi) begin
            o_term.kind = fri_pkg::KIND_ZERO;
        end else if (w_x < w_c) begin
            if (w_x < w_lsh) begin
                o_term.kind = fri_pkg::KIND_SLOPE;
                o_term.num  = w_lnum[15:0];
                o_term.den  = w_lb - w_lt;
            end
        end else if (w_x > w_rsh) begin
            o_term.kind = fri_pkg::KIND_SLOPE;
            o_term.num  = w_rnum[15:0];
            o_term.den  = w_rb - w_rt;
        end
    end

    assign o_s_tready = !i_full;
    assign o_push     = i_s_tvalid && !i_full;

endmodule

`default_nettype wire

// ----- rtl/fri_queue.sv -----
// ----------------------------------------------------------------------------
// fri_queue
// Short first-in first-out queue of classified terms between the front
// and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module fri_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire fri_pkg::t_term  i_term,
    output logic                 o_full,
    input  wire logic            i_pop,
    output fri_pkg::t_term       o_head,
    output logic                 o_empty
);

    localparam int PTR_W = (fri_pkg::QDEPTH > 1) ? $clog2(fri_pkg::QDEPTH) : 1;
    localparam int CNT_W = $clog2(fri_pkg::QDEPTH + 1);

    fri_pkg::t_term r_mem [fri_pkg::QDEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_cnt;
    logic [PTR_W-1:0] n_wptr;
    logic [PTR_W-1:0] n_rptr;

    always_comb begin
        n_wptr = (r_wptr == PTR_W'(fri_pkg::QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
        n_rptr = (r_rptr == PTR_W'(fri_pkg::QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_term;
        end
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= n_wptr;
            end
            if (i_pop) begin
                r_rptr <= n_rptr;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_head  = r_mem[r_rptr];
    assign o_full  = (r_cnt == CNT_W'(fri_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);

endmodule

`default_nettype wire

// ----- rtl/fri_div.sv -----
// ----------------------------------------------------------------------------
// fri_div
// Shared restoring divider, one quotient bit per cycle, for the slope
// degrees and the final weighted average.
// ----------------------------------------------------------------------------
`default_nettype none

module fri_div #(
    parameter int NUM_W = 39,
    parameter int DEN_W = 22
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_numer,
    input  wire logic [DEN_W-1:0] i_denom,
    output fri_pkg::t_div_res     o_res
);

    localparam int Q_W  = fri_pkg::DIV_Q_W;
    localparam int RW   = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;
    localparam int CT_W = $clog2(Q_W + 1);

    logic            r_busy;
    logic            r_done;
    logic [CT_W-1:0] r_cnt;
    logic [RW-1:0]   r_rem;
    logic [RW-1:0]   r_dsh;
    logic [Q_W-1:0]  r_q;
    logic            w_ge;
    logic [RW-1:0]   n_rem;

    always_comb begin
        w_ge  = (r_rem >= r_dsh);
        n_rem = w_ge ? r_rem - r_dsh : r_rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= RW'(i_numer);
                r_dsh  <= RW'(i_denom) << (Q_W - 1);
                r_q    <= '0;
                r_cnt  <= CT_W'(Q_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_dsh <= r_dsh >> 1;
                r_q   <= {r_q[Q_W-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_res.done   = r_done;
    assign o_res.rem_nz = |r_rem;
    assign o_res.quot   = r_q;

endmodule

`default_nettype wire

// ----- rtl/fri_back.sv -----
// ----------------------------------------------------------------------------
// fri_back
// Sequencer that finishes each term's degree, folds it into the rule
// minimum, accumulates fired rules and forms the weighted average.
// ----------------------------------------------------------------------------
`default_nettype none

module fri_back #(
    parameter int MAX_RULES = fri_pkg::MAX_RULES_DEF,
    parameter int NUM_W     = 39,
    parameter int DEN_W     = 22
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [15:0]        i_cfg_wdata,
    input  wire logic               i_empty,
    input  wire fri_pkg::t_term     i_head,
    output logic                    o_pop,
    output logic                    o_div_start,
    output logic [NUM_W-1:0]        o_div_numer,
    output logic [DEN_W-1:0]        o_div_denom,
    input  wire fri_pkg::t_div_res  i_div,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output fri_pkg::t_result        o_result
);

    localparam int CNT_W = $clog2(MAX_RULES + 1);
    localparam int CNT_X = CNT_W + 7;
    localparam int Q_W   = fri_pkg::DIV_Q_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CALC,
        S_DSTART,
        S_DWAIT,
        S_MIN,
        S_ACC,
        S_END,
        S_FWAIT,
        S_OUT
    } t_state;

    t_state                    r_state;
    fri_pkg::t_term            r_cur;
    logic [15:0]               r_deg;
    logic [31:0]               r_prod;
    logic [15:0]               r_min;
    logic [15:0]               r_peak;
    logic [15:0]               r_w;
    logic signed [32:0]        r_wprod;
    logic [DEN_W-1:0]          r_wsum;
    logic signed [NUM_W-1:0]   r_psum;
    logic [CNT_W-1:0]          r_cnt;
    logic [15:0]               r_held;
    logic                      r_neg;
    logic [15:0]               r_res;
    logic                      r_nofire;
    logic                      r_ovalid;
    fri_pkg::t_result          r_out;

    logic [15:0]               n_min;
    logic [31:0]               w_prod;
    logic signed [32:0]        w_wprod;
    logic [NUM_W-1:0]          w_abs;
    logic [Q_W:0]              n_fres;
    logic [CNT_X-1:0]          w_cnt_x;

    always_comb begin
        n_min   = (r_deg < r_min) ? r_deg : r_min;
        w_prod  = r_cur.num * r_cur.height;
        w_wprod = $signed({1'b0, n_min}) * r_cur.rule_output;
        w_abs   = r_psum[NUM_W-1] ? NUM_W'(-r_psum) : NUM_W'(r_psum);
        n_fres  = r_neg ? (-{1'b0, i_div.quot}) - (Q_W + 1)'(i_div.rem_nz)
                        : {1'b0, i_div.quot};
        w_cnt_x = CNT_X'(r_cnt);

        o_pop       = (r_state == S_IDLE) && !i_empty;
        o_div_start = (r_state == S_DSTART) ||
                      ((r_state == S_END) && r_cur.last_rule && (r_cnt != '0));
        if (r_state == S_DSTART) begin
            o_div_numer = NUM_W'(r_prod);
            o_div_denom = DEN_W'(r_cur.den);
        end else begin
            o_div_numer = w_abs;
            o_div_denom = r_wsum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_min    <= fri_pkg::PEAK_RESET;
            r_peak   <= fri_pkg::PEAK_RESET;
            r_wsum   <= '0;
            r_psum   <= '0;
            r_cnt    <= '0;
            r_held   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_peak <= i_cfg_wdata;
            end
            if (r_ovalid && i_ready && (r_state != S_OUT)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_cur   <= i_head;
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    case (r_cur.kind)
                        fri_pkg::KIND_SLOPE: begin
                            r_prod  <= w_prod;
                            r_state <= S_DSTART;
                        end
                        fri_pkg::KIND_FLAT: begin
                            r_deg   <= r_cur.height;
                            r_state <= S_MIN;
                        end
                        default: begin
                            r_deg   <= '0;
                            r_state <= S_MIN;
                        end
                    endcase
                end
                S_DSTART: begin
                    r_state <= S_DWAIT;
                end
                S_DWAIT: begin
                    if (i_div.done) begin
                        r_deg   <= i_div.quot[15:0];
                        r_state <= S_MIN;
                    end
                end
                S_MIN: begin
                    if (!(r_cur.last_term || r_cur.last_rule)) begin
                        r_min   <= n_min;
                        r_state <= S_IDLE;
                    end else begin
                        r_min   <= r_peak;
                        r_w     <= n_min;
                        r_wprod <= w_wprod;
                        if (n_min != '0 && r_cnt < CNT_W'(MAX_RULES)) begin
                            r_state <= S_ACC;
                        end else begin
                            r_state <= S_END;
                        end
                    end
                end
                S_ACC: begin
                    r_wsum  <= r_wsum + DEN_W'(r_w);
                    r_psum  <= r_psum + NUM_W'(r_wprod);
                    r_cnt   <= r_cnt + 1'b1;
                    r_state <= S_END;
                end
                S_END: begin
                    if (!r_cur.last_rule) begin
                        r_state <= S_IDLE;
                    end else if (r_cnt == '0) begin
                        r_res    <= r_held;
                        r_nofire <= 1'b1;
                        r_state  <= S_OUT;
                    end else begin
                        r_neg    <= r_psum[NUM_W-1];
                        r_nofire <= 1'b0;
                        r_state  <= S_FWAIT;
                    end
                end
                S_FWAIT: begin
                    if (i_div.done) begin
                        r_res   <= n_fres[15:0];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || i_ready) begin
                        r_ovalid            <= 1'b1;
                        r_out.crisp_output  <= r_res;
                        r_out.no_rule_fired <= r_nofire;
                        r_out.fired_rules   <= w_cnt_x[6:0];
                        r_held              <= r_res;
                        r_wsum              <= '0;
                        r_psum              <= '0;
                        r_cnt               <= '0;
                        r_state             <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid  = r_ovalid;
    assign o_result = r_out;

endmodule

`default_nettype wire

// ----- rtl/fuzzy_rule_inference.sv -----
// In the back end a flat or zero term passes IDLE, CALC and MIN, then ACC (if the rule fired
// within the limit) and END when it closes a rule; a trapezoid side term also passes DSTART
// and DWAIT on the 17-step divider. A last-rule term then takes FWAIT for the final division
// (not if none fired) and OUT; a two-entry queue decouples input, popped only in IDLE.
// Reset: synchronous, active low; clears sums, count, held output, the queue and
// the result valid flag, and sets the peak register and rule minimum to full scale.
// ----------------------------------------------------------------------------
// fuzzy_rule_inference
// Sugeno fuzzy inference over streamed antecedent terms: trapezoid degree,
// minimum per rule and weighted average of the fired rule outputs.
// ----------------------------------------------------------------------------
`default_nettype none

module fuzzy_rule_inference #(
    parameter int MAX_RULES = fri_pkg::MAX_RULES_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [15:0]   i_cfg_wdata,
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    // crisp_input, set_centre, left_base_width, left_top_width,
    // right_base_width, right_top_width, set_height, rule_output
    input  wire logic [127:0]  i_s_tdata,
    // last_rule
    input  wire logic          i_s_tlast,
    // last_term
    input  wire logic          i_s_tuser,
    output logic               o_m_tvalid,
    input  wire logic          i_m_tready,
    // crisp_output, fired_rules, one zero pad bit
    output logic [23:0]        o_m_tdata,
    // no_rule_fired
    output logic               o_m_tuser
);

    localparam int LOG_R = $clog2(MAX_RULES);
    localparam int NUM_W = 33 + LOG_R;
    localparam int DEN_W = 16 + LOG_R;

    logic              w_push;
    logic              w_full;
    logic              w_pop;
    logic              w_empty;
    fri_pkg::t_term    w_term;
    fri_pkg::t_term    w_head;
    logic              w_div_start;
    logic [NUM_W-1:0]  w_div_numer;
    logic [DEN_W-1:0]  w_div_denom;
    fri_pkg::t_div_res w_div;
    fri_pkg::t_result  w_result;

    fri_front u_front (
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_s_tuser  (i_s_tuser),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_term     (w_term)
    );

    fri_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_term  (w_term),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_empty)
    );

    fri_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_numer (w_div_numer),
        .i_denom (w_div_denom),
        .o_res   (w_div)
    );

    fri_back #(
        .MAX_RULES (MAX_RULES),
        .NUM_W     (NUM_W),
        .DEN_W     (DEN_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_empty     (w_empty),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_div_start (w_div_start),
        .o_div_numer (w_div_numer),
        .o_div_denom (w_div_denom),
        .i_div       (w_div),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_result    (w_result)
    );

    assign o_m_tdata = {1'b0, w_result.fired_rules, w_result.crisp_output};
    assign o_m_tuser = w_result.no_rule_fired;

endmodule

`default_nettype wire

// ----- rtl/fri_checker.sv -----
// ----------------------------------------------------------------------------
// fri_checker
// Port-level checks on the result stream of the fuzzy rule inference block.
// ----------------------------------------------------------------------------
`default_nettype none

module fri_checker #(
    parameter int MAX_RULES = fri_pkg::MAX_RULES_DEF
) (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [23:0] o_m_tdata,
    input wire logic        o_m_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("Result changed while stalled.");

    a_none_fired: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata[22:16] == 7'd0)
        else $error("No-fire flag with a non-zero rule count.");

    a_some_fired: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata[22:16] != 7'd0 || MAX_RULES > 127)
        else $error("Average reported with a zero rule count.");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> MAX_RULES > 127 || o_m_tdata[22:16] <= 7'(MAX_RULES))
        else $error("Fired rule count exceeds the rule limit.");

endmodule

bind fuzzy_rule_inference fri_checker #(
    .MAX_RULES (MAX_RULES)
) u_fri_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

`default_nettype wire
